// File: rtl/cpr_pkg.sv
// Shared types and codes for the clock page replacer.
// Slot status encoding, request codes, controller states and fixed field widths.
// No dependencies.
`default_nettype none

package cpr_pkg;

    // Fixed widths of the transfer fields
    localparam int FIDX_W = 6;
    localparam int HELD_W = 7;
    localparam int REQ_W  = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_VICTIM = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PIN    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UNPIN  = 2'd2;

    // Per-slot status as held in the status memory
    typedef enum logic [1:0] {
        ST_EMPTY     = 2'd0,
        ST_ACCESSED  = 2'd1,
        ST_UNTOUCHED = 2'd2
    } slot_status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_SWEEP,
        S_FINISH,
        S_REPLY
    } cpr_state_t;

endpackage

`default_nettype wire

// File: rtl/clock_page_replacer.sv
// Clock page replacer: status memory of NUM_FRAMES slots, one-read-port sweep controller.
// Pin/unpin: read-modify-write of one slot. Unknown request: reply only. Victim: one
// status memory read per slot over the whole ring, then the victim write-back.
// One request in service at a time; a result stall stretches the last cycle of a request.
// After reset the status memory is swept to empty, with req_stall high.
// Depends on cpr_pkg.
`default_nettype none

module clock_page_replacer #(
    parameter int NUM_FRAMES = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // request channel
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire logic [cpr_pkg::REQ_W-1:0]  req_type,
    input  wire logic [cpr_pkg::FIDX_W-1:0] frame_index,
    // result channel
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output logic                            found,
    output logic [cpr_pkg::FIDX_W-1:0]      victim_frame,
    output logic [cpr_pkg::HELD_W-1:0]      held_count
);

    import cpr_pkg::*;

    localparam int IDX_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
    localparam int VEXT_W = (IDX_W > FIDX_W) ? IDX_W : FIDX_W;
    localparam int HEXT_W = (CNT_W > HELD_W) ? CNT_W : HELD_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);

    // Frame index taken modulo NUM_FRAMES by restoring subtraction
    function automatic logic [IDX_W-1:0] wrap_index(input logic [FIDX_W-1:0] raw);
        logic [FIDX_W:0] r;
        r = {1'b0, raw};
        for (int k = FIDX_W - 1; k >= 0; k--) begin
            if (32'(r) >= (NUM_FRAMES << k)) begin
                r = r - (FIDX_W + 1)'(NUM_FRAMES << k);
            end
        end
        return IDX_W'(r);
    endfunction

    // Next slot around the ring
    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    // Status memory
    slot_status_t status_mem [NUM_FRAMES];
    slot_status_t rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_status_t     wr_data;

    // Control and payload registers
    cpr_state_t state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [IDX_W-1:0] hand_reg, hand_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [REQ_W-1:0] op_reg, op_next;
    logic             have_reg, have_next;
    logic [IDX_W-1:0] first_untouched_reg, first_untouched_next;
    logic             any_reg, any_next;
    logic [IDX_W-1:0] first_held_reg, first_held_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    victim_reg, victim_next;
    logic [CNT_W-1:0]    held_out_reg, held_out_next;

    logic             rsp_free;
    logic [IDX_W-1:0] chosen;
    logic [VEXT_W-1:0] victim_wide;
    logic [HEXT_W-1:0] held_wide;

    assign rsp_free = !rsp_valid_reg || !rsp_stall;
    assign chosen   = have_reg ? first_untouched_reg : first_held_reg;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == LAST_IDX)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_type) inside
                        REQ_VICTIM:       state_next = S_SWEEP;
                        REQ_PIN, REQ_UNPIN: state_next = S_UPDATE;
                        default:          state_next = S_REPLY;
                    endcase
                end
            end
            S_SWEEP:
            begin
                if (step_reg == LAST_IDX)
                    state_next = S_FINISH;
            end
            S_UPDATE, S_FINISH, S_REPLY:
            begin
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        rd_en    = 1'b0;
        rd_addr  = hand_reg;
        wr_en    = 1'b0;
        wr_addr  = scan_reg;
        wr_data  = ST_EMPTY;

        clr_cnt_next         = clr_cnt_reg;
        hand_next            = hand_reg;
        held_next            = held_reg;
        scan_next            = scan_reg;
        step_next            = step_reg;
        slot_next            = slot_reg;
        op_next              = op_reg;
        have_next            = have_reg;
        first_untouched_next = first_untouched_reg;
        any_next             = any_reg;
        first_held_next      = first_held_reg;

        rsp_valid_next = rsp_valid_reg && rsp_stall;
        found_next     = found_reg;
        victim_next    = victim_reg;
        held_out_next  = held_out_reg;

        unique case (state_reg)
            // post-reset clearing pass
            S_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = ST_EMPTY;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            // take a request and issue its first read (victim, pin and unpin requests)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next   = req_type;
                    slot_next = wrap_index(frame_index);
                    if (req_type == REQ_VICTIM)
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = hand_reg;
                        scan_next = hand_reg;
                        step_next = '0;
                        have_next = 1'b0;
                        any_next  = 1'b0;
                    end
                    else if (req_type == REQ_PIN || req_type == REQ_UNPIN)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = wrap_index(frame_index);
                    end
                end
            end
            // pin / unpin read-modify-write
            S_UPDATE:
            begin
                if (rsp_free)
                begin
                    wr_en   = 1'b1;
                    wr_addr = slot_reg;
                    if (op_reg == REQ_PIN)
                    begin
                        wr_data = ST_EMPTY;
                        if (rd_data_reg != ST_EMPTY && held_reg != '0)
                            held_next = held_reg - 1'b1;
                    end
                    else
                    begin
                        wr_data = ST_ACCESSED;
                        if (rd_data_reg == ST_EMPTY)
                            held_next = held_reg + 1'b1;
                    end
                    rsp_valid_next = 1'b1;
                    found_next     = 1'b0;
                    victim_next    = '0;
                    held_out_next  = held_next;
                end
            end
            // one slot per cycle around the ring from the hand
            S_SWEEP:
            begin
                case (rd_data_reg)
                    ST_ACCESSED:
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = scan_reg;
                        wr_data  = ST_UNTOUCHED;
                    end
                    ST_UNTOUCHED:
                    begin
                        if (!have_reg)
                        begin
                            have_next            = 1'b1;
                            first_untouched_next = scan_reg;
                        end
                    end
                    default: ;
                endcase
                if (rd_data_reg != ST_EMPTY && !any_reg)
                begin
                    any_next        = 1'b1;
                    first_held_next = scan_reg;
                end
                if (step_reg != LAST_IDX)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = ring_next(scan_reg);
                    scan_next = ring_next(scan_reg);
                    step_next = step_reg + 1'b1;
                end
            end
            // evict the victim and move the hand, if any slot holds a page; then reply
            S_FINISH:
            begin
                if (rsp_free)
                begin
                    if (any_reg)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = chosen;
                        wr_data   = ST_EMPTY;
                        hand_next = chosen;
                        if (held_reg != '0)
                            held_next = held_reg - 1'b1;
                    end
                    rsp_valid_next = 1'b1;
                    found_next     = any_reg;
                    victim_next    = any_reg ? chosen : '0;
                    held_out_next  = held_next;
                end
            end
            // unknown request: report only
            S_REPLY:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    found_next     = 1'b0;
                    victim_next    = '0;
                    held_out_next  = held_reg;
                end
            end
            default: ;
        endcase
    end

    // Status memory: one read port with registered data, one write port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= status_mem[rd_addr];
        if (wr_en)
            status_mem[wr_addr] <= wr_data;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            hand_reg      <= '0;
            held_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            hand_reg      <= hand_next;
            held_reg      <= held_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Sweep bookkeeping and result payload
    always_ff @(posedge clk)
    begin
        scan_reg            <= scan_next;
        step_reg            <= step_next;
        slot_reg            <= slot_next;
        op_reg              <= op_next;
        have_reg            <= have_next;
        first_untouched_reg <= first_untouched_next;
        any_reg             <= any_next;
        first_held_reg      <= first_held_next;
        found_reg           <= found_next;
        victim_reg          <= victim_next;
        held_out_reg        <= held_out_next;
    end

    // Port fitting to the fixed field widths
    assign victim_wide = VEXT_W'(victim_reg);
    assign held_wide   = HEXT_W'(held_out_reg);

    assign req_stall    = (state_reg != S_IDLE);
    assign rsp_valid    = rsp_valid_reg;
    assign found        = found_reg;
    assign victim_frame = victim_wide[FIDX_W-1:0];
    assign held_count   = held_wide[HELD_W-1:0];

endmodule

`default_nettype wire

// File: bench/clock_page_replacer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for clock_page_replacer: directed and random pin/unpin/victim traffic.
// A bursty sender and a stalling receiver; replies are checked against an in-bench replacer.
// Depends on cpr_pkg and the clock_page_replacer RTL.

module clock_page_replacer_tb;
    import cpr_pkg::*;

    localparam int NUM_FRAMES   = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = NUM_FRAMES + 8;
    localparam int RANDOM_ITEMS = 400;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [FIDX_W-1:0] slot;
    } frame_req_t;

    typedef struct packed {
        logic              found;
        logic [FIDX_W-1:0] victim;
        logic [HELD_W-1:0] held;
    } frame_reply_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              req_valid   = 1'b0;
    logic              req_stall;
    logic [REQ_W-1:0]  req_type    = REQ_VICTIM;
    logic [FIDX_W-1:0] frame_index = '0;
    logic              rsp_valid;
    logic              rsp_stall   = 1'b0;
    logic              found;
    logic [FIDX_W-1:0] victim_frame;
    logic [HELD_W-1:0] held_count;

    frame_req_t   req_backlog[$];
    frame_reply_t pending_replies[$];

    // Shadow copy of the replacer state
    slot_status_t      shadow_slots [NUM_FRAMES];
    logic [FIDX_W-1:0] shadow_hand;
    logic [HELD_W-1:0] shadow_held;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int stall_mode     = 0;
    int stall_left     = 0;

    clock_page_replacer #(
        .NUM_FRAMES(NUM_FRAMES)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .frame_index (frame_index),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .found       (found),
        .victim_frame(victim_frame),
        .held_count  (held_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Applies one request to the shadow state and returns the reply it should produce
    function automatic frame_reply_t predict_reply(logic [REQ_W-1:0] kind,
                                                   logic [FIDX_W-1:0] slot);
        frame_reply_t r;
        logic         any_page;
        logic         picked;
        int           pos;
        r        = '0;
        any_page = 1'b0;
        picked   = 1'b0;
        case (kind)
            REQ_PIN:
            begin
                if (shadow_slots[slot] != ST_EMPTY && shadow_held != 0)
                    shadow_held = shadow_held - 1'b1;
                shadow_slots[slot] = ST_EMPTY;
            end
            REQ_UNPIN:
            begin
                if (shadow_slots[slot] == ST_EMPTY)
                    shadow_held = shadow_held + 1'b1;
                shadow_slots[slot] = ST_ACCESSED;
            end
            REQ_VICTIM:
            begin
                // one lap from the hand: age accessed slots, note the first cold one
                for (int i = 0; i < NUM_FRAMES; i++)
                begin
                    pos = (shadow_hand + i) % NUM_FRAMES;
                    if (shadow_slots[pos] == ST_ACCESSED)
                    begin
                        any_page          = 1'b1;
                        shadow_slots[pos] = ST_UNTOUCHED;
                    end
                    else if (shadow_slots[pos] == ST_UNTOUCHED)
                    begin
                        any_page = 1'b1;
                        if (!picked)
                        begin
                            picked   = 1'b1;
                            r.victim = FIDX_W'(pos);
                        end
                    end
                end
                if (any_page)
                begin
                    // every page was recently used: take the first page from the hand
                    for (int i = 0; i < NUM_FRAMES; i++)
                    begin
                        pos = (shadow_hand + i) % NUM_FRAMES;
                        if (!picked && shadow_slots[pos] != ST_EMPTY)
                        begin
                            picked   = 1'b1;
                            r.victim = FIDX_W'(pos);
                        end
                    end
                    r.found                = 1'b1;
                    shadow_slots[r.victim] = ST_EMPTY;
                    shadow_hand            = r.victim;
                    if (shadow_held != 0)
                        shadow_held = shadow_held - 1'b1;
                end
            end
            default:
            begin
                // unknown request: no state change
            end
        endcase
        r.held = shadow_held;
        return r;
    endfunction

    task automatic add_req(input logic [REQ_W-1:0] kind, input logic [FIDX_W-1:0] slot);
        req_backlog.push_back('{kind: kind, slot: slot});
    endtask

    // Mix biased toward unpin so the ring holds pages most of the time
    function automatic logic [REQ_W-1:0] random_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return REQ_UNPIN;
        else if (roll < 70)
            return REQ_VICTIM;
        else if (roll < 93)
            return REQ_PIN;
        return REQ_UNKNOWN;
    endfunction

    // Request driver: bursts of transfers with random gaps, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        frame_req_t nxt;
        if (!rst_n)
        begin
            req_valid   <= 1'b0;
            req_type    <= REQ_VICTIM;
            frame_index <= '0;
            shadow_hand = '0;
            shadow_held = '0;
            foreach (shadow_slots[i])
                shadow_slots[i] = ST_EMPTY;
        end
        else
        begin
            if (req_valid && !req_stall)
                pending_replies.push_back(predict_reply(req_type, frame_index));
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() != 0)
                begin
                    nxt = req_backlog.pop_front();
                    req_valid   <= 1'b1;
                    req_type    <= nxt.kind;
                    frame_index <= nxt.slot;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Reply monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        frame_reply_t want;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    $error("reply transfer with nothing expected: found=%0d victim_frame=%0d",
                           found, victim_frame);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        mismatch_count++;
                    end
                    if (victim_frame !== want.victim)
                    begin
                        $error("victim_frame: expected %0d, got %0d", want.victim, victim_frame);
                        mismatch_count++;
                    end
                    if (held_count !== want.held)
                    begin
                        $error("held_count: expected %0d, got %0d", want.held, held_count);
                        mismatch_count++;
                    end
                end
            end
            // stretches of no stall, random stall, and solid stall
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = (stall_mode == 0) ? $urandom_range(1, 60) :
                             (stall_mode == 1) ? $urandom_range(1, 30) : $urandom_range(1, 12);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= 1'($urandom_range(0, 1));
                default: rsp_stall <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("clock_page_replacer regression: fail");
        $finish;
    end

    // Stimulus, reset and end of run
    initial
    begin
        int base;
        int hot;
        // nothing held yet, unknown request, pin of an empty slot
        add_req(REQ_VICTIM, 6'd63);
        add_req(REQ_UNKNOWN, 6'd63);
        add_req(REQ_PIN, 6'd5);
        add_req(REQ_UNPIN, 6'd0);
        add_req(REQ_UNPIN, 6'd63);
        add_req(REQ_UNPIN, 6'd0);
        add_req(REQ_UNPIN, 6'd42);
        add_req(REQ_UNKNOWN, 6'd0);
        // all accessed: victim is the hand slot, then the first cold slot
        add_req(REQ_VICTIM, 6'd21);
        add_req(REQ_VICTIM, 6'd0);
        // all accessed, hand slot empty: first page after the hand
        add_req(REQ_UNPIN, 6'd63);
        add_req(REQ_UNPIN, 6'd20);
        add_req(REQ_VICTIM, 6'd63);
        // mix of cold and accessed slots
        add_req(REQ_UNPIN, 6'd63);
        add_req(REQ_UNPIN, 6'd1);
        add_req(REQ_VICTIM, 6'd7);
        add_req(REQ_VICTIM, 6'd56);
        // repeated pin, then empty ring again
        add_req(REQ_PIN, 6'd1);
        add_req(REQ_PIN, 6'd1);
        add_req(REQ_VICTIM, 6'd42);
        add_req(REQ_UNPIN, 6'd63);
        add_req(REQ_VICTIM, 6'd0);
        add_req(REQ_VICTIM, 6'd63);

        // random part: full-ring fills, hot-window churn and uniform traffic
        while (req_backlog.size() < RANDOM_ITEMS + 23)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    base = $urandom_range(0, NUM_FRAMES - 1);
                    for (int k = 0; k < NUM_FRAMES; k++)
                        add_req(REQ_UNPIN, FIDX_W'(base + k));
                    repeat ($urandom_range(2, 6))
                        add_req(REQ_VICTIM, FIDX_W'($urandom));
                end
                1, 2, 3, 4:
                begin
                    hot = $urandom_range(0, NUM_FRAMES - 1);
                    repeat (20)
                        add_req(random_kind(), FIDX_W'(hot + $urandom_range(0, 7)));
                end
                default:
                begin
                    repeat (20)
                        add_req(random_kind(), FIDX_W'($urandom));
                end
            endcase
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_valid)
            @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("clock_page_replacer regression: pass");
        else
            $display("clock_page_replacer regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/cpr_pkg.sv
rtl/clock_page_replacer.sv
bench/clock_page_replacer_tb.sv
